FILE: rtl/tst_pkg.sv
// package for the topic subscription table
// shared sizes, status codes and the front-to-back request type; no dependencies
package tst_pkg;
  localparam int unsigned TopicSlots = 64;
  localparam int unsigned SubsPerTopic = 64;
  localparam int unsigned ClientIdBits = 10;
  localparam int unsigned SlotBits = $clog2(TopicSlots);
  localparam int unsigned SubBits = $clog2(SubsPerTopic);
  localparam int unsigned TopicCntBits = $clog2(TopicSlots + 1);
  localparam int unsigned SubCntBits = $clog2(SubsPerTopic + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrBits = 1;

  typedef enum logic [2:0] {
    StAdded     = 3'd0,
    StAlready   = 3'd1,
    StTableFull = 3'd2,
    StListFull  = 3'd3,
    StDeliver   = 3'd4,
    StNoTopic   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OpSubscribe = 2'd0,
    OpPublish   = 2'd1,
    OpReply     = 2'd2
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [SlotBits-1:0]     slot;
    logic                    fresh;
    status_e                 status;
    logic [ClientIdBits-1:0] client;
  } req_t;
endpackage

FILE: rtl/tst_front.sv
// front end: topic key lookup by serial scan of the topic name memory
// depends on tst_pkg; issues classified requests into the queue
module tst_front import tst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [63:0]             topic_key_i,
  input  logic [ClientIdBits-1:0] client_id_i,
  output logic                    req_valid_o,
  input  logic                    req_ready_i,
  output req_t                    req_o
);
  typedef enum logic [3:0] {
    FIdle = 4'b0001,
    FScan = 4'b0010,
    FComp = 4'b0100,
    FIssue = 4'b1000
  } fstate_e;

  fstate_e                 state_q, state_d;
  logic [63:0]             names [TopicSlots];
  logic [63:0]             rd_q;
  logic [TopicCntBits-1:0] used_q, used_d;
  logic [TopicCntBits-1:0] idx_q, idx_d;
  logic                    cmd_q;
  logic [63:0]             key_q;
  logic [ClientIdBits-1:0] cli_q;
  req_t                    req_q, req_d;
  logic                    wr_en;

  assign in_ready_o  = (state_q == FIdle);
  assign req_valid_o = (state_q == FIssue);
  assign req_o       = req_q;

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    idx_d   = idx_q;
    req_d   = req_q;
    wr_en   = 1'b0;
    unique case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          idx_d   = '0;
          state_d = FScan;
        end
      end
      FScan: begin
        req_d.client = cli_q;
        req_d.fresh  = 1'b0;
        req_d.status = StAdded;
        if (idx_q >= used_q) begin
          state_d = FIssue;
          if (cmd_q) begin
            req_d.op     = OpReply;
            req_d.status = StNoTopic;
            req_d.client = '0;
          end else if (used_q >= TopicCntBits'(TopicSlots)) begin
            req_d.op     = OpReply;
            req_d.status = StTableFull;
          end else begin
            wr_en       = 1'b1;
            req_d.op    = OpSubscribe;
            req_d.slot  = used_q[SlotBits-1:0];
            req_d.fresh = 1'b1;
            used_d      = used_q + 1'b1;
          end
        end else begin
          state_d = FComp;
        end
      end
      FComp: begin
        if (rd_q == key_q) begin
          req_d.op   = cmd_q ? OpPublish : OpSubscribe;
          req_d.slot = idx_q[SlotBits-1:0];
          state_d    = FIssue;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = FScan;
        end
      end
      FIssue: begin
        if (req_ready_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && in_valid_i) begin
      cmd_q <= command_i;
      key_q <= topic_key_i;
      cli_q <= client_id_i;
    end
    if (wr_en) names[used_q[SlotBits-1:0]] <= key_q;
    rd_q  <= names[idx_q[SlotBits-1:0]];
    req_q <= req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= TopicCntBits'(TopicSlots)) else $error("topic count overflow");
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
    else $error("topic count jumped");
  a_issue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_o && !req_ready_i |=> req_valid_o && $stable(req_o))
    else $error("request changed while stalled");
endmodule

FILE: rtl/tst_queue.sv
// short request queue between the front and back ends
// depends on tst_pkg
module tst_queue import tst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  req_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output req_t rd_data_o
);
  req_t                  mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wp_q, rp_q;
  logic [QueuePtrBits:0]   cnt_q;
  logic push, pop;

  assign wr_ready_o = (cnt_q != (QueuePtrBits+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrBits+1)'(push) - (QueuePtrBits+1)'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrBits+1)'(QueueDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (QueuePtrBits+1)'(QueueDepth)) |-> wp_q == rp_q)
    else $error("queue pointers out of step");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost push");
endmodule

FILE: rtl/tst_back.sv
// back end: subscriber list memory, duplicate scan, append and publish fan-out
// depends on tst_pkg; takes requests from the queue, drives results
module tst_back import tst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  req_t                    req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [ClientIdBits-1:0] target_client_o,
  output logic                    last_o
);
  typedef enum logic [5:0] {
    BIdle  = 6'b000001,
    BCnt   = 6'b000010,
    BRead  = 6'b000100,
    BComp  = 6'b001000,
    BOut   = 6'b010000,
    BWait  = 6'b100000
  } bstate_e;

  localparam int unsigned AddrBits = SlotBits + SubBits;

  bstate_e                 state_q, state_d;
  logic [ClientIdBits-1:0] lists [TopicSlots*SubsPerTopic];
  logic [SubCntBits-1:0]   counts [TopicSlots];
  logic [ClientIdBits-1:0] lrd_q;
  logic [SubCntBits-1:0]   crd_q;
  req_t                    cur_q;
  logic [SubCntBits-1:0]   cnt_q, cnt_d;
  logic [SubCntBits-1:0]   idx_q, idx_d;
  logic [2:0]              st_q, st_d;
  logic [ClientIdBits-1:0] tg_q, tg_d;
  logic                    last_q, last_d;
  logic                    ov_q, ov_d;
  logic                    lwr, cwr;
  logic [AddrBits-1:0]     raddr, waddr;

  assign req_ready_o     = (state_q == BIdle);
  assign out_valid_o     = ov_q;
  assign status_o        = st_q;
  assign target_client_o = tg_q;
  assign last_o          = last_q;
  assign raddr = {cur_q.slot, idx_q[SubBits-1:0]};
  assign waddr = {cur_q.slot, cnt_q[SubBits-1:0]};

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; idx_d = idx_q;
    st_d = st_q; tg_d = tg_q; last_d = last_q;
    ov_d = ov_q && !out_ready_i;
    lwr = 1'b0; cwr = 1'b0;
    unique case (state_q)
      BIdle: begin
        if (req_valid_i) begin
          idx_d   = '0;
          state_d = (req_i.op == OpReply) ? BOut : BCnt;
        end
      end
      BCnt: begin
        cnt_d   = cur_q.fresh ? '0 : crd_q;
        state_d = BRead;
      end
      BRead: begin
        if (idx_q >= cnt_q) begin
          if (!ov_q) begin
            if (cur_q.op == OpPublish) begin
              st_d = StNoTopic; tg_d = '0; last_d = 1'b1;
            end else if (cnt_q >= SubCntBits'(SubsPerTopic)) begin
              st_d = StListFull; tg_d = cur_q.client; last_d = 1'b1;
            end else begin
              lwr = 1'b1; cwr = 1'b1;
              st_d = StAdded; tg_d = cur_q.client; last_d = 1'b1;
            end
            state_d = BWait;
          end
        end else begin
          state_d = BComp;
        end
      end
      BComp: begin
        if (cur_q.op == OpPublish) begin
          if (!ov_q) begin
            st_d = StDeliver; tg_d = lrd_q;
            last_d = (idx_q + 1'b1 == cnt_q);
            idx_d = idx_q + 1'b1;
            state_d = BWait;
          end
        end else if (lrd_q == cur_q.client) begin
          if (!ov_q) begin
            st_d = StAlready; tg_d = cur_q.client; last_d = 1'b1;
            state_d = BWait;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = BRead;
        end
      end
      BOut: begin
        if (!ov_q) begin
          st_d = cur_q.status; tg_d = cur_q.client; last_d = 1'b1;
          state_d = BWait;
        end
      end
      BWait: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          state_d = last_q ? BIdle : BRead;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BIdle && req_valid_i) cur_q <= req_i;
    if (lwr) lists[waddr] <= cur_q.client;
    if (cwr) counts[cur_q.slot] <= cnt_q + 1'b1;
    lrd_q <= lists[raddr];
    crd_q <= counts[req_i.slot];
    st_q <= st_d; tg_q <= tg_d; last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle; cnt_q <= '0; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= SubCntBits'(SubsPerTopic)) else $error("list index overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
    && $stable(target_client_o)) else $error("result changed while stalled");
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BWait && !ov_q |=> ov_q) else $error("result not presented");
endmodule

FILE: rtl/topic_subscription_table.sv
// top level of the topic subscription table
// depends on tst_pkg, tst_front, tst_queue, tst_back
// Subscribe and publish commands arrive one at a time. The front end scans the
// stored topic keys one by one (up to 64 slots) and hands a request through a
// two-entry queue to the back end. The back end scans the subscriber list entry
// by entry for a subscribe, and for a publish sends one deliver transfer per
// subscriber, paced by the registered read of the list memory and the output
// register, and held while the receiver stalls.
module topic_subscription_table import tst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [63:0]             topic_key_i,
  input  logic [ClientIdBits-1:0] client_id_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [ClientIdBits-1:0] target_client_o,
  output logic                    last_o
);
  req_t f_req, b_req;
  logic f_valid, f_ready, b_valid, b_ready;

  tst_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .topic_key_i,
    .client_id_i, .req_valid_o(f_valid), .req_ready_i(f_ready), .req_o(f_req)
  );

  tst_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i(f_req), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o(b_req)
  );

  tst_back u_back (
    .clk_i, .rst_ni, .req_valid_i(b_valid), .req_ready_o(b_ready),
    .req_i(b_req), .out_valid_o, .out_ready_i, .status_o, .target_client_o,
    .last_o
  );
endmodule

FILE: tb/topic_subscription_table_tb.sv
// testbench for topic_subscription_table: random and directed subscribe/publish traffic
// checked against a behavioral table model; depends on tst_pkg and the rtl
`timescale 1ns / 1ps

module topic_subscription_table_tb;
  import tst_pkg::*;

  typedef struct {
    logic                    cmd;
    logic [63:0]             key;
    logic [ClientIdBits-1:0] client;
  } command_t;

  typedef struct {
    status_e                 status;
    logic [ClientIdBits-1:0] target;
    logic                    last;
  } reply_t;

  localparam logic CmdSubscribe = 1'b0;
  localparam logic CmdPublish   = 1'b1;
  localparam int   IdleLimit    = 20000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    command_i;
  logic [63:0]             topic_key_i;
  logic [ClientIdBits-1:0] client_id_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [2:0]              status_o;
  logic [ClientIdBits-1:0] target_client_o;
  logic                    last_o;

  topic_subscription_table DUT (.*);

  // behavioral copy of the table
  logic [63:0]             topic_keys[TopicSlots];
  int                      model_topics;
  logic [ClientIdBits-1:0] member_ids[TopicSlots][SubsPerTopic];
  int                      member_count[TopicSlots];

  command_t pending_cmds[$];
  reply_t   expected_replies[$];
  int       error_count;
  int       idle_cycles;
  bit       stim_done;
  bit       hold_off;
  int       send_wait;
  int       recv_wait;
  logic [63:0] key_pool[8];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void predict_replies(input command_t c);
    int slot;
    int n;
    reply_t r;
    slot = -1;
    for (int i = 0; i < model_topics; i++)
      if (slot < 0 && topic_keys[i] == c.key) slot = i;
    r.target = c.client;
    r.last = 1'b1;
    if (c.cmd == CmdSubscribe) begin
      if (slot < 0) begin
        if (model_topics >= TopicSlots) begin
          r.status = StTableFull;
          expected_replies.push_back(r);
          return;
        end
        slot = model_topics;
        topic_keys[slot] = c.key;
        member_count[slot] = 0;
        model_topics++;
      end
      n = member_count[slot];
      for (int i = 0; i < n; i++)
        if (member_ids[slot][i] == c.client) begin
          r.status = StAlready;
          expected_replies.push_back(r);
          return;
        end
      if (n >= SubsPerTopic) begin
        r.status = StListFull;
      end else begin
        member_ids[slot][n] = c.client;
        member_count[slot] = n + 1;
        r.status = StAdded;
      end
      expected_replies.push_back(r);
    end else begin
      if (slot < 0 || member_count[slot] == 0) begin
        r.status = StNoTopic;
        r.target = '0;
        expected_replies.push_back(r);
        return;
      end
      n = member_count[slot];
      for (int i = 0; i < n; i++) begin
        r.status = StDeliver;
        r.target = member_ids[slot][i];
        r.last = (i == n - 1);
        expected_replies.push_back(r);
      end
    end
  endfunction

  function automatic command_t make_cmd(input logic cmd, input logic [63:0] key,
                                        input logic [ClientIdBits-1:0] client);
    command_t c;
    c.cmd = cmd;
    c.key = key;
    c.client = client;
    return c;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      command_i   <= 1'b0;
      topic_key_i <= '0;
      client_id_i <= '0;
      send_wait   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_replies(make_cmd(command_i, topic_key_i, client_id_i));
        void'(pending_cmds.pop_front());
        send_wait <= $urandom_range(0, 10);
      end
      if ((!in_valid_i || in_ready_o) && pending_cmds.size() > 0
          && (send_wait == 0 || (in_valid_i && in_ready_o && $urandom_range(0, 3) == 0)))
          begin
        in_valid_i  <= 1'b1;
        command_i   <= pending_cmds[0].cmd;
        topic_key_i <= pending_cmds[0].key;
        client_id_i <= pending_cmds[0].client;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end else if (!in_valid_i && send_wait > 0) begin
        send_wait <= send_wait - 1;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result transfer");
        end else begin
          if (status_o !== expected_replies[0].status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o,
                                      expected_replies[0].status));
          if (target_client_o !== expected_replies[0].target)
            report_mismatch($sformatf("target %0d, expected %0d", target_client_o,
                                      expected_replies[0].target));
          if (last_o !== expected_replies[0].last)
            report_mismatch($sformatf("last %0b, expected %0b", last_o,
                                      expected_replies[0].last));
          void'(expected_replies.pop_front());
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        recv_wait <= $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      idle_cycles <= 0;
    else if (pending_cmds.size() > 0 || expected_replies.size() > 0 || !stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [ClientIdBits-1:0] cid;
    int k;
    error_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    hold_off = 1'b0;
    model_topics = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    pending_cmds.push_back(make_cmd(CmdPublish, 64'h0, 10'd0));
    pending_cmds.push_back(make_cmd(CmdSubscribe, 64'h0, 10'd0));
    pending_cmds.push_back(make_cmd(CmdSubscribe, 64'h0, 10'd1023));
    pending_cmds.push_back(make_cmd(CmdSubscribe, 64'h0, 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, 64'h0, 10'd555));
    pending_cmds.push_back(make_cmd(CmdSubscribe, '1, 10'h2aa));
    pending_cmds.push_back(make_cmd(CmdSubscribe, '1, 10'h155));
    pending_cmds.push_back(make_cmd(CmdPublish, '1, 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, 64'h5555_5555_5555_5555, 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, 64'haaaa_aaaa_aaaa_aaaa, 10'd1023));

    // fill one subscriber list to overflow, with a long receiver hold-off
    for (int i = 0; i < SubsPerTopic + 2; i++)
      pending_cmds.push_back(make_cmd(CmdSubscribe, key_pool[2], 10'(i * 7)));
    pending_cmds.push_back(make_cmd(CmdSubscribe, key_pool[2], 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, key_pool[2], 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, key_pool[2], 10'd0));
    pending_cmds.push_back(make_cmd(CmdPublish, key_pool[1], 10'd0));
    wait (pending_cmds.size() < 8);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    wait (pending_cmds.size() == 0 && expected_replies.size() == 0);

    // random part: pool keys mostly, fresh keys fill the topic table
    for (int i = 0; i < 240; i++) begin
      k = $urandom_range(0, 9);
      cid = (k < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      if (k < 6)
        pending_cmds.push_back(make_cmd($urandom_range(0, 2) == 0, key_pool[k],
                                        cid));
      else
        pending_cmds.push_back(make_cmd($urandom_range(0, 3) == 0,
                                        {$urandom, $urandom}, cid));
      if (i == 120) wait (pending_cmds.size() == 0);
    end
    wait (pending_cmds.size() == 0);
    // table full
    for (int i = 0; i < 50; i++)
      pending_cmds.push_back(make_cmd(CmdSubscribe, {32'hdead0000, 32'(i)}, 10'(i)));
    for (int i = 0; i < 5; i++)
      pending_cmds.push_back(make_cmd(CmdPublish, key_pool[$urandom_range(0, 5)],
                                      10'($urandom)));
    wait (pending_cmds.size() == 0);
    stim_done = 1'b1;
    wait (expected_replies.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sim.f
rtl/tst_pkg.sv
rtl/tst_front.sv
rtl/tst_queue.sv
rtl/tst_back.sv
rtl/topic_subscription_table.sv
tb/topic_subscription_table_tb.sv
